// File: design/assert_macros.svh
// Assertion macros used by buffer_level_rate_control.sv.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// The consequent holds at the same edge as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent holds at the edge after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: design/blrc_pkg.sv
`timescale 1ns / 1ps

package blrc_pkg;

    localparam int BUFFER_SIZE_DEF = 4096;
    localparam int HISTORY_DEPTH   = 32;
    localparam int HIST_W          = $clog2(HISTORY_DEPTH);

    localparam int LEVEL_W   = 12;
    localparam int FRAMES_W  = 12;
    localparam int OFFSET_W  = 13;
    localparam int SUM_W     = 18;
    localparam int SMAG_W    = SUM_W - 1;
    localparam int GAIN_W    = 48;
    localparam int RATIO_W   = 32;
    localparam int PROD_W    = GAIN_W + SMAG_W;
    localparam int FRAC_SHIFT = HIST_W + 10;
    localparam int QUOT_W    = PROD_W - FRAC_SHIFT;

    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 5;

    localparam logic [1:0] REG_TARGET_LEVEL = 2'd0;
    localparam logic [1:0] REG_LOOP_GAIN    = 2'd1;
    localparam logic [1:0] REG_DRAIN_CHUNK  = 2'd2;

    localparam logic OP_ARRIVAL = 1'b0;
    localparam logic OP_DRAIN   = 1'b1;

    localparam logic [LEVEL_W-1:0] TARGET_RESET = 12'd2048;
    localparam logic [LEVEL_W-1:0] CHUNK_RESET  = 12'd256;
    localparam logic [GAIN_W-1:0]  GAIN_RESET   = 48'd10995116;

    localparam logic [RATIO_W-1:0] ONE_Q30        = 32'h4000_0000;
    localparam logic [RATIO_W-1:0] RATIO_HEADROOM = 32'hBFFF_FFFF;

endpackage

// File: design/blrc_history.sv
`timescale 1ns / 1ps

module blrc_history (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    input  logic signed [blrc_pkg::OFFSET_W-1:0] i_offset,
    output logic signed [blrc_pkg::SUM_W-1:0]    o_sum_next
);

    logic signed [blrc_pkg::OFFSET_W-1:0] r_hist [blrc_pkg::HISTORY_DEPTH];
    logic        [blrc_pkg::HIST_W-1:0]   r_slot;
    logic signed [blrc_pkg::SUM_W-1:0]    r_sum;
    logic signed [blrc_pkg::OFFSET_W-1:0] oldest;

    assign oldest     = r_hist[r_slot];
    assign o_sum_next = r_sum + blrc_pkg::SUM_W'(i_offset) - blrc_pkg::SUM_W'(oldest);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < blrc_pkg::HISTORY_DEPTH; i++) begin
                r_hist[i] <= '0;
            end
            r_slot <= '0;
            r_sum  <= '0;
        end else if (i_push) begin
            r_hist[r_slot] <= i_offset;
            r_slot         <= r_slot + 1'b1;
            r_sum          <= o_sum_next;
        end
    end

endmodule

// File: design/buffer_level_rate_control.sv
`timescale 1ns / 1ps
// Throughput: one item per cycle while the input is not stalled by a full pipeline.
// Four pipeline registers (input, state update, multiply, saturate); an output stall holds
// every full stage with no empty stage after it; with all full, the input stalls that cycle.
// Reset (synchronous, active low) restores the register reset values, sets the write
// pointer to the target and the read pointer to zero, and clears the offset history.

`include "assert_macros.svh"

module buffer_level_rate_control #(
    parameter int BUFFER_SIZE = blrc_pkg::BUFFER_SIZE_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,

    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_operation,
    input  logic [blrc_pkg::FRAMES_W-1:0]         i_generated_frames,

    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [blrc_pkg::RATIO_W-1:0]          o_rate_ratio,
    output logic signed [blrc_pkg::OFFSET_W-1:0]  o_average_offset,
    output logic [blrc_pkg::LEVEL_W-1:0]          o_queued_samples,
    output logic                                  o_drained,
    output logic [blrc_pkg::LEVEL_W-1:0]          o_fill_level,

    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [blrc_pkg::CFG_ADDR_W-1:0]       paddr,
    input  logic [blrc_pkg::CFG_DATA_W-1:0]       pwdata,
    output logic [blrc_pkg::CFG_DATA_W-1:0]       prdata,
    output logic                                  pready
);

    localparam int PW = $clog2(BUFFER_SIZE);
    localparam int XW = ((PW > 13) ? PW : 13) + 1;
    localparam logic [PW-1:0] PTR_MASK = '1;
    localparam logic [XW-1:0] WP_RESET_X = XW'(blrc_pkg::TARGET_RESET);
    localparam logic [blrc_pkg::SUM_W-1:0] AVG_BIAS =
        blrc_pkg::SUM_W'(blrc_pkg::HISTORY_DEPTH - 1);

    // Configuration registers and buffer pointers
    logic [blrc_pkg::LEVEL_W-1:0] r_target;
    logic [blrc_pkg::GAIN_W-1:0]  r_gain;
    logic [blrc_pkg::LEVEL_W-1:0] r_chunk;
    logic [PW-1:0]                r_wp;
    logic [PW-1:0]                r_rp;

    // Pipeline registers
    logic                         r_s0_valid;
    logic                         r_s0_op;
    logic [blrc_pkg::FRAMES_W-1:0] r_s0_frames;

    logic                         r_s1_valid;
    logic                         r_s1_op;
    logic signed [blrc_pkg::OFFSET_W-1:0] r_s1_avg;
    logic [blrc_pkg::LEVEL_W-1:0] r_s1_queued;
    logic                         r_s1_drained;
    logic [blrc_pkg::LEVEL_W-1:0] r_s1_fill;
    logic                         r_s1_sneg;
    logic [blrc_pkg::SMAG_W-1:0]  r_s1_smag;

    logic                         r_s2_valid;
    logic                         r_s2_op;
    logic signed [blrc_pkg::OFFSET_W-1:0] r_s2_avg;
    logic [blrc_pkg::LEVEL_W-1:0] r_s2_queued;
    logic                         r_s2_drained;
    logic [blrc_pkg::LEVEL_W-1:0] r_s2_fill;
    logic                         r_s2_neg;
    logic [blrc_pkg::PROD_W-1:0]  r_s2_prod;

    logic                         r_out_valid;
    logic [blrc_pkg::RATIO_W-1:0] r_out_ratio;
    logic signed [blrc_pkg::OFFSET_W-1:0] r_out_avg;
    logic [blrc_pkg::LEVEL_W-1:0] r_out_queued;
    logic                         r_out_drained;
    logic [blrc_pkg::LEVEL_W-1:0] r_out_fill;

    logic free_out, free_s2, free_s1, free_s0, adv_s1;
    logic cfg_wr;
    logic [1:0] cfg_idx;
    logic [XW-1:0] wtarget_x;

    assign cfg_wr    = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[blrc_pkg::CFG_ADDR_W-1:3];
    assign wtarget_x = XW'(pwdata[blrc_pkg::LEVEL_W-1:0]);
    assign pready    = 1'b1;

    always_comb begin
        case (cfg_idx)
            blrc_pkg::REG_TARGET_LEVEL: prdata = blrc_pkg::CFG_DATA_W'(r_target);
            blrc_pkg::REG_LOOP_GAIN:    prdata = blrc_pkg::CFG_DATA_W'(r_gain);
            blrc_pkg::REG_DRAIN_CHUNK:  prdata = blrc_pkg::CFG_DATA_W'(r_chunk);
            default:                    prdata = '0;
        endcase
    end

    // Stage advance chain; a stage loads when it is empty or its content moves on.
    assign free_out   = !r_out_valid || !i_out_stall;
    assign free_s2    = !r_s2_valid || free_out;
    assign free_s1    = !r_s1_valid || free_s2;
    assign free_s0    = !r_s0_valid || free_s1;
    assign adv_s1     = free_s1 && r_s0_valid;
    assign o_in_stall = !free_s0;

    // State update for the item in the input register
    logic [PW-1:0]   fill;
    logic [XW-1:0]   fill_x, target_x, room_x, want_x, queued_x, chunk_x, fill_after_x;
    logic signed [XW-1:0] off_raw, off_min;
    logic signed [blrc_pkg::OFFSET_W-1:0] offset;
    logic signed [blrc_pkg::SUM_W-1:0] sum_next, avg_biased;
    logic            sneg, can_drain, push;
    logic [blrc_pkg::SUM_W-1:0] sum_abs;

    assign fill     = r_wp - r_rp;
    assign fill_x   = XW'(fill);
    assign target_x = XW'(r_target);
    assign off_raw  = $signed(target_x) - $signed(fill_x);
    assign off_min  = -$signed(target_x);
    assign offset   = (off_raw < off_min) ? off_min[blrc_pkg::OFFSET_W-1:0]
                                          : off_raw[blrc_pkg::OFFSET_W-1:0];

    assign push = adv_s1 && (r_s0_op == blrc_pkg::OP_ARRIVAL);

    blrc_history u_history (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_offset   (offset),
        .o_sum_next (sum_next)
    );

    assign sneg       = sum_next[blrc_pkg::SUM_W-1];
    assign sum_abs    = sneg ? -sum_next : sum_next;
    assign avg_biased = sum_next + (sneg ? $signed(AVG_BIAS) : '0);

    assign room_x    = XW'(PTR_MASK) - fill_x;
    assign want_x    = XW'({r_s0_frames, 1'b0});
    assign queued_x  = (room_x < want_x) ? room_x : want_x;
    assign chunk_x   = XW'(r_chunk);
    assign can_drain = (r_chunk != '0) && (fill_x >= chunk_x);

    always_comb begin
        if (r_s0_op == blrc_pkg::OP_ARRIVAL) begin
            fill_after_x = fill_x + queued_x;
        end else if (can_drain) begin
            fill_after_x = fill_x - chunk_x;
        end else begin
            fill_after_x = fill_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= blrc_pkg::TARGET_RESET;
            r_gain   <= blrc_pkg::GAIN_RESET;
            r_chunk  <= blrc_pkg::CHUNK_RESET;
            r_wp     <= WP_RESET_X[PW-1:0];
            r_rp     <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                blrc_pkg::REG_TARGET_LEVEL: begin
                    r_target <= pwdata[blrc_pkg::LEVEL_W-1:0];
                    r_wp     <= wtarget_x[PW-1:0];
                    r_rp     <= '0;
                end
                blrc_pkg::REG_LOOP_GAIN:   r_gain  <= pwdata[blrc_pkg::GAIN_W-1:0];
                blrc_pkg::REG_DRAIN_CHUNK: r_chunk <= pwdata[blrc_pkg::LEVEL_W-1:0];
                default: ;
            endcase
        end else if (adv_s1) begin
            if (r_s0_op == blrc_pkg::OP_ARRIVAL) begin
                r_wp <= r_wp + queued_x[PW-1:0];
            end else if (can_drain) begin
                r_rp <= r_rp + chunk_x[PW-1:0];
            end
        end
    end

    // Multiply stage inputs
    logic                        gneg;
    logic [blrc_pkg::GAIN_W-1:0] gmag;

    assign gneg = r_gain[blrc_pkg::GAIN_W-1];
    assign gmag = gneg ? (~r_gain + 1'b1) : r_gain;

    // Saturation stage
    logic [blrc_pkg::QUOT_W-1:0]  quot;
    logic [blrc_pkg::RATIO_W-1:0] ratio;

    assign quot = r_s2_prod[blrc_pkg::PROD_W-1:blrc_pkg::FRAC_SHIFT];

    always_comb begin
        if (r_s2_op == blrc_pkg::OP_DRAIN) begin
            ratio = '0;
        end else if (r_s2_neg) begin
            ratio = (quot >= blrc_pkg::QUOT_W'(blrc_pkg::ONE_Q30)) ? '0 :
                    blrc_pkg::ONE_Q30 - quot[blrc_pkg::RATIO_W-1:0];
        end else begin
            ratio = (quot > blrc_pkg::QUOT_W'(blrc_pkg::RATIO_HEADROOM)) ? '1 :
                    blrc_pkg::ONE_Q30 + quot[blrc_pkg::RATIO_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid  <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (free_s0) begin
                r_s0_valid <= i_in_valid;
            end
            if (free_s1) begin
                r_s1_valid <= r_s0_valid;
            end
            if (free_s2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (free_out) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (free_s0) begin
            r_s0_op     <= i_operation;
            r_s0_frames <= i_generated_frames;
        end
        if (free_s1) begin
            r_s1_op      <= r_s0_op;
            r_s1_fill    <= fill_after_x[blrc_pkg::LEVEL_W-1:0];
            r_s1_sneg    <= sneg;
            r_s1_smag    <= sum_abs[blrc_pkg::SMAG_W-1:0];
            if (r_s0_op == blrc_pkg::OP_ARRIVAL) begin
                r_s1_avg     <= avg_biased[blrc_pkg::SUM_W-1:blrc_pkg::HIST_W];
                r_s1_queued  <= queued_x[blrc_pkg::LEVEL_W-1:0];
                r_s1_drained <= 1'b0;
            end else begin
                r_s1_avg     <= '0;
                r_s1_queued  <= '0;
                r_s1_drained <= can_drain;
            end
        end
        if (free_s2) begin
            r_s2_op      <= r_s1_op;
            r_s2_avg     <= r_s1_avg;
            r_s2_queued  <= r_s1_queued;
            r_s2_drained <= r_s1_drained;
            r_s2_fill    <= r_s1_fill;
            r_s2_neg     <= gneg ^ r_s1_sneg;
            r_s2_prod    <= blrc_pkg::PROD_W'(gmag) * blrc_pkg::PROD_W'(r_s1_smag);
        end
        if (free_out) begin
            r_out_ratio   <= ratio;
            r_out_avg     <= r_s2_avg;
            r_out_queued  <= r_s2_queued;
            r_out_drained <= r_s2_drained;
            r_out_fill    <= r_s2_fill;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_rate_ratio     = r_out_ratio;
    assign o_average_offset = r_out_avg;
    assign o_queued_samples = r_out_queued;
    assign o_drained        = r_out_drained;
    assign o_fill_level     = r_out_fill;

    `ASSERT_SAME(a_stall_when_full, o_in_stall,
        r_s0_valid && r_s1_valid && r_s2_valid && r_out_valid,
        "Input stalled while the pipeline has an empty stage.")
    `ASSERT_SAME(a_drain_result_clean, o_out_valid && o_drained,
        o_rate_ratio == '0 && o_queued_samples == '0 && o_average_offset == '0,
        "Drain result carries arrival fields.")
    `ASSERT_NEXT(a_arrival_keeps_read,
        adv_s1 && r_s0_op == blrc_pkg::OP_ARRIVAL && !cfg_wr,
        r_rp == $past(r_rp), "Arrival moved the read pointer.")
    `ASSERT_NEXT(a_drain_keeps_write,
        adv_s1 && r_s0_op == blrc_pkg::OP_DRAIN && !cfg_wr,
        r_wp == $past(r_wp), "Drain moved the write pointer.")

endmodule
